// ===== rtl/mac_pkg.sv =====
// Shared types and constants for the moving average crossover block.
package mac_pkg;

    // Field widths fixed by the item format.
    localparam int SYM_W     = 16;
    localparam int PRICE_W   = 32;
    localparam int WIN_W     = 9;
    localparam int SUM_W     = 40;
    localparam int AVG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Bars held between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FAST_WINDOW    = 2'd0,
        CFG_SLOW_WINDOW    = 2'd1,
        CFG_WATCHED_SYMBOL = 2'd2
    } cfg_index_t;

    // Trade signal codes.
    typedef enum logic [1:0] {
        SIG_NONE = 2'd0,
        SIG_BUY  = 2'd1,
        SIG_SELL = 2'd2
    } sig_t;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAUNCH,
        ST_DIVIDE,
        ST_FINISH
    } back_state_t;

    // One input bar.
    typedef struct packed {
        logic [SYM_W-1:0]   symbol_id;
        logic [PRICE_W-1:0] close_price;
    } mac_in_t;

    // One result item.
    typedef struct packed {
        sig_t             signal;
        logic [AVG_W-1:0] fast_average;
        logic [AVG_W-1:0] slow_average;
        logic             window_ready;
        logic             config_error;
    } mac_out_t;

    // Effective window settings handed to the back end.
    typedef struct packed {
        logic [WIN_W-1:0] fast_win;
        logic [WIN_W-1:0] slow_win;
        logic             cfg_err;
    } win_cfg_t;

endpackage

// ===== rtl/mac_queue.sv =====
// Small FIFO that holds watched bar prices between the front and the back end.
module mac_queue #(
    parameter int DATA_W = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] din,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] dout,
    output logic              not_empty
);
    import mac_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

    logic [DATA_W-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign dout      = slot_reg[rd_ptr_reg];

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

`ifndef SYNTH
    // The front never writes into a full queue.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full || pop) else $error("queue written while full");

    // The back never reads an empty queue.
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty) else $error("queue read while empty");

    // A lone write raises the fill level by one.
    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("queue level did not follow a write");
`endif

endmodule

// ===== rtl/mac_front.sv =====
// Front end: takes bars, drops foreign symbols and queues watched prices.
module mac_front #(
    parameter int HIST_W = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  mac_pkg::mac_in_t         s_data,
    input  logic [mac_pkg::SYM_W-1:0] watched_symbol,
    output logic                     q_valid,
    output logic [HIST_W-1:0]        q_price,
    input  logic                     q_pop
);
    import mac_pkg::*;

    logic q_full;
    logic watched;
    logic push;

    // A bar is taken whenever the queue has room; only watched bars are queued.
    assign s_ready = !q_full;
    assign watched = (s_data.symbol_id == watched_symbol);
    assign push    = s_valid && !q_full && watched;

    mac_queue #(
        .DATA_W (HIST_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .din       (s_data.close_price[HIST_W-1:0]),
        .full      (q_full),
        .pop       (q_pop),
        .dout      (q_price),
        .not_empty (q_valid)
    );

endmodule

// ===== rtl/mac_div.sv =====
// Restoring divider: a 40-bit sum by a window length, one quotient bit per cycle.
module mac_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [mac_pkg::SUM_W-1:0] dividend,
    input  logic [mac_pkg::WIN_W-1:0] divisor,
    output logic                      done,
    output logic [mac_pkg::SUM_W-1:0] quotient
);
    import mac_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SUM_W - 1);

    logic             busy_reg, done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [WIN_W-1:0] rem_reg, dvs_reg, rem_next;
    logic [SUM_W-1:0] quo_reg;
    logic [WIN_W:0]   trial, diff;
    logic             ge;

    // One restoring step: bring in the next dividend bit and try a subtract.
    always_comb begin
        trial    = {rem_reg, quo_reg[SUM_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        ge       = (trial >= {1'b0, dvs_reg});
        rem_next = ge ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    // Step counter and completion pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST_CNT) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Dividend shifts out at the top while quotient bits shift in at the bottom.
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[SUM_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

endmodule

// ===== rtl/mac_back.sv =====
// Back end: price history, window sums, averages, crossover logic and result register.
module mac_back #(
    parameter int MAX_WINDOW = 256,
    parameter int HIST_W     = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  logic [HIST_W-1:0] q_price,
    output logic              q_pop,
    input  mac_pkg::win_cfg_t cfg,
    output logic              m_valid,
    input  logic              m_ready,
    output mac_pkg::mac_out_t m_data
);
    import mac_pkg::*;

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WINDOW - 1);

    logic [HIST_W-1:0] hist_mem [MAX_WINDOW];

    back_state_t      state_reg, state_next;
    logic [AW-1:0]    wpos_reg, rd_addr_reg;
    logic [WIN_W-1:0] fill_reg, len_reg, issue_cnt_reg, acc_cnt_reg;
    logic             do_fast_reg, do_slow_reg, rd_vld_reg;
    logic [HIST_W-1:0] rd_data_reg;
    logic [SUM_W-1:0] acc_reg, fast_sum_reg, acc_sum;
    logic [SUM_W-1:0] cur_fast_reg, cur_slow_reg, prev_fast_reg, prev_slow_reg;
    logic [SUM_W-1:0] fast_quo, slow_quo;
    logic             holding_reg, out_valid_reg;
    mac_out_t         out_reg;

    logic [WIN_W-1:0] fill_clip, fill_new, scan_len, acc_cnt_inc;
    logic             take_fast, take_slow;
    logic             rd_en, scan_last, div_start, fast_done, slow_done;
    logic             out_free, finish, window_ready, cross_up, cross_down;
    sig_t             sig;

    // Fill level after this bar and how far back the history must be summed.
    always_comb begin
        fill_clip = (fill_reg > cfg.slow_win) ? cfg.slow_win : fill_reg;
        fill_new  = (fill_clip < cfg.slow_win) ? fill_clip + WIN_W'(1) : fill_clip;
        take_fast = (fill_new >= cfg.fast_win);
        take_slow = (fill_new >= cfg.slow_win);
        if (take_slow) begin
            scan_len = cfg.slow_win;
        end else if (take_fast) begin
            scan_len = cfg.fast_win;
        end else begin
            scan_len = '0;
        end
    end

    // Scan datapath: newest entry first, one read per cycle.
    assign rd_en       = (state_reg == ST_SCAN) && (issue_cnt_reg < len_reg);
    assign acc_sum     = acc_reg + SUM_W'(rd_data_reg);
    assign acc_cnt_inc = acc_cnt_reg + WIN_W'(1);
    assign scan_last   = rd_vld_reg && (acc_cnt_inc == len_reg);
    assign out_free    = !out_valid_reg || m_ready;

    // Crossover decision on the averages of this bar.
    always_comb begin
        window_ready = (fill_reg >= cfg.slow_win);
        cross_up     = (prev_fast_reg <= prev_slow_reg) && (cur_fast_reg > cur_slow_reg);
        cross_down   = (prev_fast_reg >= prev_slow_reg) && (cur_fast_reg < cur_slow_reg);
        sig          = SIG_NONE;
        if (window_ready && !cfg.cfg_err) begin
            if (cross_up && !holding_reg) begin
                sig = SIG_BUY;
            end else if (cross_down && holding_reg) begin
                sig = SIG_SELL;
            end
        end
    end

    // Sequencer state register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequencer next state and strobes.
    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        div_start  = 1'b0;
        finish     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    state_next = (scan_len == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_LAUNCH;
                end
            end
            ST_LAUNCH: begin
                div_start  = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (fast_done && slow_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and the running strategy state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wpos_reg      <= '0;
            fill_reg      <= '0;
            issue_cnt_reg <= '0;
            acc_cnt_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            cur_fast_reg  <= '0;
            cur_slow_reg  <= '0;
            prev_fast_reg <= '0;
            prev_slow_reg <= '0;
            holding_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            rd_vld_reg <= rd_en;
            if (q_pop) begin
                wpos_reg      <= (wpos_reg == LAST_ADDR) ? '0 : wpos_reg + AW'(1);
                fill_reg      <= fill_new;
                issue_cnt_reg <= '0;
                acc_cnt_reg   <= '0;
            end
            if (rd_en) begin
                issue_cnt_reg <= issue_cnt_reg + WIN_W'(1);
            end
            if (rd_vld_reg) begin
                acc_cnt_reg <= acc_cnt_inc;
            end
            if ((state_reg == ST_DIVIDE) && fast_done && slow_done) begin
                if (do_fast_reg) begin
                    cur_fast_reg <= fast_quo;
                end
                if (do_slow_reg) begin
                    cur_slow_reg <= slow_quo;
                end
            end
            if (finish) begin
                out_valid_reg <= 1'b1;
                if (window_ready && !cfg.cfg_err) begin
                    prev_fast_reg <= cur_fast_reg;
                    prev_slow_reg <= cur_slow_reg;
                    if (sig == SIG_BUY) begin
                        holding_reg <= 1'b1;
                    end else if (sig == SIG_SELL) begin
                        holding_reg <= 1'b0;
                    end
                end
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // History memory, scan accumulator and result payload.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            hist_mem[wpos_reg] <= q_price;
            rd_addr_reg        <= wpos_reg;
            len_reg            <= scan_len;
            do_fast_reg        <= take_fast;
            do_slow_reg        <= take_slow;
            acc_reg            <= '0;
        end
        if (rd_en) begin
            rd_data_reg <= hist_mem[rd_addr_reg];
            rd_addr_reg <= (rd_addr_reg == '0) ? LAST_ADDR : rd_addr_reg - AW'(1);
        end
        if (rd_vld_reg) begin
            acc_reg <= acc_sum;
            if (do_fast_reg && (acc_cnt_inc == cfg.fast_win)) begin
                fast_sum_reg <= acc_sum;
            end
        end
        if (finish) begin
            out_reg.signal       <= sig;
            out_reg.fast_average <= cur_fast_reg[AVG_W-1:0];
            out_reg.slow_average <= cur_slow_reg[AVG_W-1:0];
            out_reg.window_ready <= window_ready;
            out_reg.config_error <= cfg.cfg_err;
        end
    end

    // Two dividers run side by side on the fast and slow sums.
    mac_div u_div_fast (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (fast_sum_reg),
        .divisor  (cfg.fast_win),
        .done     (fast_done),
        .quotient (fast_quo)
    );

    mac_div u_div_slow (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (cfg.slow_win),
        .done     (slow_done),
        .quotient (slow_quo)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTH
    // Both dividers are started together and must finish together.
    a_div_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        fast_done == slow_done) else $error("dividers out of step");

    // A division only completes while the sequencer waits for it.
    a_div_in_state: assert property (@(posedge aclk) disable iff (!aresetn)
        fast_done |-> state_reg == ST_DIVIDE) else $error("stray divider completion");

    // Returned read data never runs past the requested scan length.
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_vld_reg |-> acc_cnt_reg < len_reg) else $error("history scan overran");

    // Closing an item always leaves a result on the output.
    a_finish_out: assert property (@(posedge aclk) disable iff (!aresetn)
        finish |=> m_valid) else $error("result lost at finish");
`endif

endmodule

// ===== rtl/moving_average_crossover_top.sv =====
// Top level of the dual moving average crossover detector.
//
// Usage notes:
//   s_valid/s_ready/s_data carry one price bar per transfer (symbol id and
//   closing price). Bars for other symbols are taken and dropped without a
//   result; each watched bar gives exactly one result on m_valid/m_ready/m_data.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the fast window (index 0),
//   slow window (index 1) and watched symbol (index 2); write only when idle.
//   A watched bar leaves the queue when the back end is idle. The back end
//   sums L history entries, where L is the slow window once full, else the
//   fast window once full; they are read one per cycle before two 40-step
//   restoring dividers. With nothing to sum the dividers are skipped and the
//   result is registered directly.
//   A two-entry queue sits in front of the back end, so bars keep being taken
//   while one is in work; the result sits in an output register, and when the
//   receiver stalls the back end waits there and the queue fills, after which
//   s_ready drops.
//   Reset (synchronous, active low) loads windows 20 and 50, symbol 0, an
//   empty history, zero averages and no open position. No clearing pass.
module moving_average_crossover_top #(
    parameter int MAX_WINDOW = 256,
    parameter int PRICE_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  mac_pkg::mac_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output mac_pkg::mac_out_t             m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mac_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mac_pkg::CFG_DAT_W-1:0] cfg_data
);
    import mac_pkg::*;

    localparam int HIST_W = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;

    logic [WIN_W-1:0] fast_window_reg, slow_window_reg;
    logic [SYM_W-1:0] watched_symbol_reg;
    logic [WIN_W-1:0] fast_eff, slow_eff;
    win_cfg_t         win_cfg;
    logic             q_valid, q_pop;
    logic [HIST_W-1:0] q_price;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fast_window_reg    <= WIN_W'(20);
            slow_window_reg    <= WIN_W'(50);
            watched_symbol_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_FAST_WINDOW:    fast_window_reg    <= cfg_data[WIN_W-1:0];
                CFG_SLOW_WINDOW:    slow_window_reg    <= cfg_data[WIN_W-1:0];
                CFG_WATCHED_SYMBOL: watched_symbol_reg <= cfg_data[SYM_W-1:0];
                default: ;
            endcase
        end
    end

    // Zero windows act as one, oversized windows as the history depth.
    always_comb begin
        if (fast_window_reg == '0) begin
            fast_eff = WIN_W'(1);
        end else if (32'(fast_window_reg) > MAX_WINDOW) begin
            fast_eff = WIN_W'(MAX_WINDOW);
        end else begin
            fast_eff = fast_window_reg;
        end
        if (slow_window_reg == '0) begin
            slow_eff = WIN_W'(1);
        end else if (32'(slow_window_reg) > MAX_WINDOW) begin
            slow_eff = WIN_W'(MAX_WINDOW);
        end else begin
            slow_eff = slow_window_reg;
        end
        win_cfg.fast_win = fast_eff;
        win_cfg.slow_win = slow_eff;
        win_cfg.cfg_err  = (fast_eff >= slow_eff);
    end

    mac_front #(
        .HIST_W (HIST_W)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .watched_symbol (watched_symbol_reg),
        .q_valid        (q_valid),
        .q_price        (q_price),
        .q_pop          (q_pop)
    );

    mac_back #(
        .MAX_WINDOW (MAX_WINDOW),
        .HIST_W     (HIST_W)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_price (q_price),
        .q_pop   (q_pop),
        .cfg     (win_cfg),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
